/* hw/rtl/integer_to_ascii_formatter_macros.svh */
// Assertion macros for the port-level checker of the formatter.
// No dependencies; each file that asserts includes this header.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// condition must hold at every clock edge out of reset
`define I2A_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define I2A_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define I2A_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/i2a_pkg.sv */
// Package of the integer to ASCII formatter: widths, command codes,
// FSM states, chain control struct and the digit to character function.
package i2a_pkg;

   localparam int VALUE_W  = 64;
   localparam int CMD_W    = 3;
   localparam int DIGIT_W  = 4;
   localparam int DIGITS   = 16;
   localparam int CNT_W    = $clog2(VALUE_W);
   localparam int REMAIN_W = $clog2(DIGITS + 1);

   localparam logic [CMD_W-1:0] CMD_SDEC     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_UDEC     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_HEX32_LO = 3'd2;
   localparam logic [CMD_W-1:0] CMD_HEX32_UP = 3'd3;
   localparam logic [CMD_W-1:0] CMD_HEX64_LO = 3'd4;
   localparam logic [CMD_W-1:0] CMD_HEX64_UP = 3'd5;

   localparam logic [31:0] SIGNED_MIN = 32'h8000_0000;

   localparam logic [7:0] ASCII_ZERO    = 8'h30;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_MINUS   = 8'h2D;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_SKIP,
      ST_EMIT,
      ST_EMPTY
   } state_type;

   // control of the digit chain, one cycle at a time
   typedef struct packed {
      logic load;      // clear digits, load binary word
      logic shift;     // shift one binary bit into the digits
      logic emit;      // move digits one place toward the top
      logic decimal;   // apply the BCD add-3 correction
   } chain_ctrl_type;

   function automatic logic [7:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                 input logic upper);
      logic [7:0] base;
      base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
      if (d < 4'd10) begin
         return ASCII_ZERO + {4'd0, d};
      end
      return base + {4'd0, d} - 8'd10;
   endfunction

endpackage

/* hw/rtl/i2a_cell.sv */
// One digit cell of the conversion chain.
// Depends on i2a_pkg for the control struct and digit width.
module i2a_cell (
   input  logic                        clock,
   input  i2a_pkg::chain_ctrl_type     ctrl,
   input  logic [i2a_pkg::DIGIT_W-1:0] digit_in,   // from lower neighbor
   input  logic                        carry_in,   // from lower neighbor
   output logic [i2a_pkg::DIGIT_W-1:0] digit,
   output logic                        carry_out
);

   logic [i2a_pkg::DIGIT_W-1:0] digit_ff, digit_in_nxt, adj;

   // add-3 when the digit would overflow on doubling
   assign adj = (ctrl.decimal && digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign carry_out = adj[i2a_pkg::DIGIT_W-1];
   assign digit = digit_ff;

   always_comb begin
      digit_in_nxt = digit_ff;
      if (ctrl.load) begin
         digit_in_nxt = '0;
      end else if (ctrl.shift) begin
         digit_in_nxt = {adj[i2a_pkg::DIGIT_W-2:0], carry_in};
      end else if (ctrl.emit) begin
         digit_in_nxt = digit_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_nxt;
   end

endmodule

/* hw/rtl/i2a_chain.sv */
// Binary shift register feeding a row of digit cells (bit-serial double dabble).
// Depends on i2a_pkg and i2a_cell.
module i2a_chain (
   input  logic                        clock,
   input  i2a_pkg::chain_ctrl_type     ctrl,
   input  logic [i2a_pkg::VALUE_W-1:0] load_word,
   output logic [i2a_pkg::DIGIT_W-1:0] top_digit
);

   logic [i2a_pkg::VALUE_W-1:0] bin_ff, bin_in;
   logic [i2a_pkg::DIGITS:0]    carry_link;
   logic [i2a_pkg::DIGIT_W-1:0] digit_link [i2a_pkg::DIGITS+1];

   assign carry_link[0] = bin_ff[i2a_pkg::VALUE_W-1];
   assign digit_link[0] = '0;
   assign top_digit = digit_link[i2a_pkg::DIGITS];

   always_comb begin
      bin_in = bin_ff;
      if (ctrl.load) begin
         bin_in = load_word;
      end else if (ctrl.shift) begin
         bin_in = {bin_ff[i2a_pkg::VALUE_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
   end

   for (genvar i = 0; i < i2a_pkg::DIGITS; i++) begin : g_cell
      i2a_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .digit_in  (digit_link[i]),
         .carry_in  (carry_link[i]),
         .digit     (digit_link[i+1]),
         .carry_out (carry_link[i+1])
      );
   end

endmodule

/* hw/rtl/integer_to_ascii_formatter.sv */
// Top level of the integer to ASCII formatter: sequencer and output register.
// Depends on i2a_pkg and i2a_chain.
//
// Use: present one number per req beat: tdata is the 64-bit value, tuser
// carries the command and the zero-precision flag. The block answers with
// one rsp beat per ASCII character, most significant first, tlast on the
// final one. An empty conversion (zero with zero precision, or an unknown
// command) gives a single beat with the empty flag set and character 0.
// The signed minimum gives "-2147483648" with the sign flag on every beat.
// Timing: after the req beat the chain shifts in 32 bits (decimal, hex32)
// or 64 bits (hex64), one per cycle, then skips leading zero digits one
// cell per cycle, moves on to the first kept digit, and emits one
// character per cycle while the receiver takes them.
// req_tready is high only while idle; the next number is taken while the
// last character still sits in the rsp register.
// A stalled receiver freezes emission; the rsp beat holds until taken.
// Reset (synchronous) returns to idle and drops rsp_tvalid.
module integer_to_ascii_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // [63:0] value
   input  logic [3:0]  req_tuser,    // [2:0] cmd, [3] precision_zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] character
   output logic        rsp_tlast,    // last
   output logic [1:0]  rsp_tuser     // [0] empty_res, [1] sign_cleared
);

   i2a_pkg::state_type state_ff, state_in;

   logic [i2a_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [i2a_pkg::REMAIN_W-1:0] remain_ff, remain_in;
   logic upper_ff, upper_in, decimal_ff, decimal_in, minus_ff, minus_in;

   logic       rsp_valid_ff, rsp_last_ff;
   logic [7:0] rsp_data_ff;
   logic [1:0] rsp_user_ff;

   // request decode
   logic [i2a_pkg::CMD_W-1:0]   cmd;
   logic [31:0]                 lo, mag32;
   logic [i2a_pkg::VALUE_W-1:0] num, load_word;
   logic wide, is_min, is_empty, req_fire;

   // sequencer outputs
   i2a_pkg::chain_ctrl_type     ctrl;
   logic [i2a_pkg::DIGIT_W-1:0] top_digit;
   logic       out_load, out_last, out_empty, slot_free, skip_go;
   logic [7:0] out_char;

   assign cmd      = req_tuser[2:0];
   assign lo       = req_tdata[31:0];
   assign is_min   = (cmd == i2a_pkg::CMD_SDEC) && (lo == i2a_pkg::SIGNED_MIN);
   // negative signed values print their magnitude; the minimum maps onto itself
   assign mag32    = (cmd == i2a_pkg::CMD_SDEC && lo[31]) ? 32'd0 - lo : lo;
   assign wide     = cmd inside {i2a_pkg::CMD_HEX64_LO, i2a_pkg::CMD_HEX64_UP};
   assign num      = wide ? req_tdata : {32'd0, mag32};
   // 32-bit modes enter the chain from the top of the shift register
   assign load_word = wide ? req_tdata : {mag32, 32'd0};
   assign is_empty = (cmd > i2a_pkg::CMD_HEX64_UP) || (num == '0 && req_tuser[3]);

   assign req_tready = (state_ff == i2a_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign skip_go    = (top_digit == '0) && (remain_ff > 1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         i2a_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = is_empty ? i2a_pkg::ST_EMPTY : i2a_pkg::ST_CONVERT;
            end
         end
         i2a_pkg::ST_CONVERT: begin
            if (cnt_ff == '0) begin
               state_in = minus_ff ? i2a_pkg::ST_SIGN : i2a_pkg::ST_SKIP;
            end
         end
         i2a_pkg::ST_SIGN: begin
            if (slot_free) begin
               state_in = i2a_pkg::ST_SKIP;
            end
         end
         i2a_pkg::ST_SKIP: begin
            if (!skip_go) begin
               state_in = i2a_pkg::ST_EMIT;
            end
         end
         i2a_pkg::ST_EMIT: begin
            if (slot_free && remain_ff == 1) begin
               state_in = i2a_pkg::ST_IDLE;
            end
         end
         i2a_pkg::ST_EMPTY: begin
            if (slot_free) begin
               state_in = i2a_pkg::ST_IDLE;
            end
         end
         default: state_in = i2a_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctrl         = '0;
      ctrl.decimal = decimal_ff;
      out_load     = 1'b0;
      out_char     = i2a_pkg::digit_to_ascii(top_digit, upper_ff);
      out_last     = (remain_ff == 1);
      out_empty    = 1'b0;
      case (state_ff)
         i2a_pkg::ST_IDLE:    ctrl.load  = req_fire;
         i2a_pkg::ST_CONVERT: ctrl.shift = 1'b1;
         i2a_pkg::ST_SIGN: begin
            out_load = slot_free;
            out_char = i2a_pkg::ASCII_MINUS;
            out_last = 1'b0;
         end
         i2a_pkg::ST_SKIP:    ctrl.emit = skip_go;
         i2a_pkg::ST_EMIT: begin
            out_load  = slot_free;
            ctrl.emit = slot_free;
         end
         i2a_pkg::ST_EMPTY: begin
            out_load  = slot_free;
            out_char  = 8'd0;
            out_last  = 1'b1;
            out_empty = 1'b1;
         end
         default: ctrl = '0;
      endcase
   end

   // item context and counters
   always_comb begin
      cnt_in     = cnt_ff;
      remain_in  = remain_ff;
      upper_in   = upper_ff;
      decimal_in = decimal_ff;
      minus_in   = minus_ff;
      if (ctrl.load) begin
         cnt_in     = wide ? i2a_pkg::CNT_W'(i2a_pkg::VALUE_W - 1)
                           : i2a_pkg::CNT_W'(i2a_pkg::VALUE_W / 2 - 1);
         remain_in  = i2a_pkg::REMAIN_W'(i2a_pkg::DIGITS);
         upper_in   = cmd inside {i2a_pkg::CMD_HEX32_UP, i2a_pkg::CMD_HEX64_UP};
         decimal_in = cmd inside {i2a_pkg::CMD_SDEC, i2a_pkg::CMD_UDEC};
         minus_in   = is_min;
      end else if (ctrl.shift) begin
         cnt_in = cnt_ff - 1'b1;
      end else if (ctrl.emit) begin
         remain_in = remain_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2a_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      remain_ff  <= remain_in;
      upper_ff   <= upper_in;
      decimal_ff <= decimal_in;
      minus_ff   <= minus_in;
      if (out_load) begin
         rsp_data_ff <= out_char;
         rsp_last_ff <= out_last;
         rsp_user_ff <= {minus_ff && !out_empty, out_empty};
      end
   end

   i2a_chain u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .load_word (load_word),
      .top_digit (top_digit)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* hw/rtl/i2a_checker.sv */
// Port-level checks of the formatter, bound to the top level.
// Depends on integer_to_ascii_formatter_macros.svh.
`include "integer_to_ascii_formatter_macros.svh"

module i2a_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   // a stalled beat holds
   `I2A_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "rsp beat changed while stalled")

   // an empty result is a lone, final beat with no character and no sign
   `I2A_ASSERT_SAME(a_empty_form, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast && rsp_tdata == 8'd0 && !rsp_tuser[1], "malformed empty beat")

   // a real character is never zero
   `I2A_ASSERT_ALWAYS(a_char_nonzero, clock, reset, !rsp_tvalid || rsp_tuser[0] || rsp_tdata != 8'd0, "zero character on non-empty beat")

   // one number at a time: no request taken right after another
   `I2A_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while busy")

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (.*);

/* bench/integer_to_ascii_formatter_checker.sv */
`timescale 1ns / 100ps
// Checker for the integer to ASCII formatter: watches the req and rsp streams,
// predicts the character beats of every accepted number and compares them.
// Depends on i2a_pkg for command codes and ASCII constants.
module integer_to_ascii_formatter_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,    // [63:0] value
   input  logic [3:0]  req_tuser,    // [2:0] cmd, [3] precision_zero
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,    // [7:0] character
   input  logic        rsp_tlast,
   input  logic [1:0]  rsp_tuser,    // [0] empty_res, [1] sign_cleared
   output int          errors,
   output int          pending,
   output int          checked
);

   typedef struct packed {
      logic [7:0] code;
      logic       final_char;
      logic       empty_str;
      logic       sign_done;
   } ascii_beat_type;

   ascii_beat_type char_queue[$];
   int             error_total = 0;
   int             beat_total  = 0;

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      error_total++;
      $display("[%0t] mismatch, %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   function automatic void push_char(input logic [7:0] code, input logic final_char,
                                     input logic empty_str, input logic sign_done);
      ascii_beat_type beat;
      beat.code       = code;
      beat.final_char = final_char;
      beat.empty_str  = empty_str;
      beat.sign_done  = sign_done;
      char_queue.push_back(beat);
   endfunction

   // digits of one number, most significant first
   function automatic void format_number(input logic [2:0] cmd, input logic [63:0] value,
                                         input logic pzero);
      logic [31:0] lo;
      logic [63:0] mag;
      logic [63:0] radix;
      logic        upper;
      logic [3:0]  d;
      logic [7:0]  c;
      logic [7:0]  text[$];
      string       minus_text;
      lo    = value[31:0];
      mag   = '0;
      radix = 64'd10;
      upper = 1'b0;
      case (cmd)
         i2a_pkg::CMD_SDEC: begin
            if (lo == i2a_pkg::SIGNED_MIN) begin
               minus_text = "-2147483648";
               for (int k = 0; k < minus_text.len(); k++)
                  push_char(minus_text[k], k == minus_text.len() - 1, 1'b0, 1'b1);
               return;
            end
            // other negatives are predicted as their magnitude, with no sign
            mag = lo[31] ? {32'd0, ~lo + 32'd1} : {32'd0, lo};
         end
         i2a_pkg::CMD_UDEC: mag = {32'd0, lo};
         i2a_pkg::CMD_HEX32_LO, i2a_pkg::CMD_HEX32_UP: begin
            mag   = {32'd0, lo};
            radix = 64'd16;
            upper = (cmd == i2a_pkg::CMD_HEX32_UP);
         end
         i2a_pkg::CMD_HEX64_LO, i2a_pkg::CMD_HEX64_UP: begin
            mag   = value;
            radix = 64'd16;
            upper = (cmd == i2a_pkg::CMD_HEX64_UP);
         end
         default: begin
            push_char(8'd0, 1'b1, 1'b1, 1'b0);
            return;
         end
      endcase
      if (mag == 64'd0 && pzero) begin
         push_char(8'd0, 1'b1, 1'b1, 1'b0);
         return;
      end
      do begin
         d = 4'(mag % radix);
         if (d > 4'd9)
            c = (upper ? i2a_pkg::ASCII_UPPER_A : i2a_pkg::ASCII_LOWER_A)
                + {4'd0, d - 4'd10};
         else
            c = i2a_pkg::ASCII_ZERO + {4'd0, d};
         text.push_front(c);
         mag = mag / radix;
      end while (mag != 64'd0);
      foreach (text[k])
         push_char(text[k], k == text.size() - 1, 1'b0, 1'b0);
   endfunction

   always @(posedge clock) begin : watch
      ascii_beat_type want;
      if (reset) begin
         char_queue.delete();
      end else begin
         // compare before predicting: a beat never belongs to a number taken this edge
         if (rsp_tvalid && rsp_tready) begin
            beat_total++;
            if (char_queue.size() == 0) begin
               report_mismatch("beat with no character pending", rsp_tdata, 8'd0);
            end else begin
               want = char_queue.pop_front();
               if (rsp_tdata !== want.code)
                  report_mismatch("character", rsp_tdata, want.code);
               if (rsp_tlast !== want.final_char)
                  report_mismatch("last flag", {7'd0, rsp_tlast}, {7'd0, want.final_char});
               if (rsp_tuser[0] !== want.empty_str)
                  report_mismatch("empty flag", {7'd0, rsp_tuser[0]}, {7'd0, want.empty_str});
               if (rsp_tuser[1] !== want.sign_done)
                  report_mismatch("sign flag", {7'd0, rsp_tuser[1]}, {7'd0, want.sign_done});
            end
         end
         if (req_tvalid && req_tready)
            format_number(req_tuser[2:0], req_tdata, req_tuser[3]);
      end
      errors  <= error_total;
      pending <= char_queue.size();
      checked <= beat_total;
   end

endmodule

/* bench/integer_to_ascii_formatter_tb.sv */
`timescale 1ns / 100ps
// Top of the formatter bench: clock, reset, number stimulus, rsp back-pressure
// and the verdict. Depends on i2a_pkg, the formatter and its checker.
module integer_to_ascii_formatter_tb;

   // the two command codes the block does not define; both give one empty beat
   localparam logic [i2a_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
   localparam logic [i2a_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

   // length of each forced receiver hold-off, in cycles
   localparam int HOLD_CYCLES = 400;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // [63:0] value
   logic [3:0]  req_tuser  = '0;   // [2:0] cmd, [3] precision_zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] character
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;         // [0] empty_res, [1] sign_cleared

   int errors;
   int pending;
   int checked;

   // idle mix of each side, in percent of cycles
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // hold-off handshake between stimulus and the receiver process
   int hold_asked = 0;
   int hold_taken = 0;

   int numbers_sent = 0;
   int cmd_count[8];

   always #5 clock = ~clock;

   integer_to_ascii_formatter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   integer_to_ascii_formatter_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .errors     (errors),
      .pending    (pending),
      .checked    (checked)
   );

   // Offer one number: optional idle gap, then hold the beat until taken.
   // Inputs move on the falling edge; tready is looked at on the rising edge.
   task automatic send_number(input logic [2:0] cmd, input logic [63:0] value,
                              input logic pzero);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= {pzero, cmd};
      do @(posedge clock); while (!req_tready);
      numbers_sent++;
      cmd_count[cmd]++;
   endtask

   // Random value shaped toward the interesting corners; the upper word is
   // left random where only the low word matters, to show it is ignored.
   function automatic logic [63:0] random_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(9))
         0: v = $urandom_range(1) ? 64'd0 : {v[63:32], 32'd0};
         1: v = v >> $urandom_range(63);
         2: v = {v[63:32], i2a_pkg::SIGNED_MIN};
         3: v = {v[63:32], 32'hFFFF_FFFF - $urandom_range(15)};
         4: v = {v[63:32], i2a_pkg::SIGNED_MIN - 32'd1 - $urandom_range(3)};
         5: v = 64'($urandom_range(20));
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_random(input int count);
      logic [2:0] cmd;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(15) == 0)
            cmd = $urandom_range(1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
         else
            cmd = 3'($urandom_range(i2a_pkg::CMD_HEX64_UP, i2a_pkg::CMD_SDEC));
         send_number(cmd, random_value(), 1'($urandom_range(1)));
      end
   endtask

   // Receiver: random stalls per the current mix, plus long hold-offs on request.
   // The hold is counted here so the sender keeps pushing and the block backs up.
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Safety net well above the slowest legal run
   initial begin : watchdog
      #20_000_000;
      $display("integer_to_ascii_formatter regression: fail");
      $finish;
   end

   initial begin : stimulus
      int wait_cycles;
      foreach (cmd_count[k])
         cmd_count[k] = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // phase one: sender idles lightly, receiver heavily
      send_idle_pct = 31;
      recv_idle_pct = 63;

      // zero with and without zero precision, over several commands
      send_number(i2a_pkg::CMD_SDEC,     64'd0, 1'b1);
      send_number(i2a_pkg::CMD_SDEC,     64'd0, 1'b0);
      send_number(i2a_pkg::CMD_UDEC,     64'd0, 1'b1);
      send_number(i2a_pkg::CMD_HEX32_LO, 64'd0, 1'b0);
      send_number(i2a_pkg::CMD_HEX64_UP, 64'd0, 1'b1);
      // low word zero but upper word set: 32-bit modes still see zero
      send_number(i2a_pkg::CMD_HEX32_UP, 64'h1234_5678_0000_0000, 1'b1);
      send_number(i2a_pkg::CMD_SDEC,     64'hFFFF_FFFF_0000_0000, 1'b0);
      // signed minimum, its neighbors and minus one
      send_number(i2a_pkg::CMD_SDEC,     {32'hFFFF_FFFF, i2a_pkg::SIGNED_MIN}, 1'b1);
      send_number(i2a_pkg::CMD_SDEC,     {32'd0, i2a_pkg::SIGNED_MIN - 32'd1}, 1'b0);
      send_number(i2a_pkg::CMD_SDEC,     {32'd0, i2a_pkg::SIGNED_MIN + 32'd1}, 1'b0);
      send_number(i2a_pkg::CMD_SDEC,     64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      // unsigned extremes; the minimum bit pattern is not special here
      send_number(i2a_pkg::CMD_UDEC,     64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_number(i2a_pkg::CMD_UDEC,     {32'hA5A5_A5A5, i2a_pkg::SIGNED_MIN}, 1'b0);
      send_number(i2a_pkg::CMD_UDEC,     64'd9, 1'b0);
      send_number(i2a_pkg::CMD_UDEC,     64'd10, 1'b1);
      // hex in both cases and both widths
      send_number(i2a_pkg::CMD_HEX32_LO, 64'hCAFE_F00D_DEAD_BEEF, 1'b0);
      send_number(i2a_pkg::CMD_HEX32_UP, 64'h0000_0000_ABCD_EF01, 1'b1);
      send_number(i2a_pkg::CMD_HEX64_LO, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_number(i2a_pkg::CMD_HEX64_UP, 64'hFEDC_BA98_7654_3210, 1'b0);
      send_number(i2a_pkg::CMD_HEX64_LO, 64'd1, 1'b1);
      send_number(i2a_pkg::CMD_HEX64_LO, 64'h8000_0000_0000_0000, 1'b1);
      // undefined commands: empty beat whatever the value
      send_number(CMD_UNUSED_LO, 64'h0123_4567_89AB_CDEF, 1'b0);
      send_number(CMD_UNUSED_HI, 64'd0, 1'b1);

      // receiver stops for a long stretch while numbers keep coming
      hold_asked++;
      send_random(160);

      // phase two: the mix turned round
      send_idle_pct = 63;
      recv_idle_pct = 31;
      send_random(160);

      // phase three: full rate both ways, with one more long hold-off
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_asked++;
      send_random(150);

      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain: every predicted character must come out
      for (wait_cycles = 0; pending != 0 && wait_cycles < 50_000; wait_cycles++)
         @(posedge clock);
      if (pending != 0) begin
         $display("characters still outstanding: %0d", pending);
         $display("integer_to_ascii_formatter regression: fail");
         $finish;
      end else begin
         // room for any stray beat to show up
         repeat (100) @(posedge clock);
         $display("converted %0d numbers: signed %0d, unsigned %0d, hex32 %0d, hex64 %0d,",
                  numbers_sent, cmd_count[i2a_pkg::CMD_SDEC], cmd_count[i2a_pkg::CMD_UDEC],
                  cmd_count[i2a_pkg::CMD_HEX32_LO] + cmd_count[i2a_pkg::CMD_HEX32_UP],
                  cmd_count[i2a_pkg::CMD_HEX64_LO] + cmd_count[i2a_pkg::CMD_HEX64_UP]);
         $display("undefined %0d; %0d character beats compared under stalls and hold-offs",
                  cmd_count[CMD_UNUSED_LO] + cmd_count[CMD_UNUSED_HI], checked);
         if (errors == 0)
            $display("integer_to_ascii_formatter regression: pass");
         else
            $display("integer_to_ascii_formatter regression: fail");
         $finish;
      end
   end

endmodule
